>>> src/lfm_pkg.sv
package lfm_pkg;

	// sample width of every loop reading
	localparam int unsigned SAMPLE_BITS = 12;
	localparam int unsigned LIMIT_BITS  = 12;
	localparam int unsigned NUM_LOOPS   = 4;
	localparam int unsigned NUM_REFS    = 2;

	// configuration register indexes
	localparam logic [1:0] REG_OPEN_LIMIT  = 2'd0;
	localparam logic [1:0] REG_SHORT_LIMIT = 2'd1;
	localparam logic [1:0] REG_ALARM_LIMIT = 2'd2;

	// configuration reset values
	localparam logic [LIMIT_BITS-1:0] OPEN_LIMIT_RST  = LIMIT_BITS'(500);
	localparam logic [LIMIT_BITS-1:0] SHORT_LIMIT_RST = LIMIT_BITS'(2850);
	localparam logic [LIMIT_BITS-1:0] ALARM_LIMIT_RST = LIMIT_BITS'(2600);

	// action codes of an input beat
	localparam logic [2:0] ACT_POLARITY    = 3'd0;
	localparam logic [2:0] ACT_CHECK       = 3'd1;
	localparam logic [2:0] ACT_BLINK       = 3'd2;
	localparam logic [2:0] ACT_BUZZ_TOGGLE = 3'd3;
	localparam logic [2:0] ACT_BUZZ_STOP   = 3'd4;

	typedef struct packed {
		logic [2:0]             action;
		logic [SAMPLE_BITS-1:0] sample_zero;
		logic [SAMPLE_BITS-1:0] sample_one;
		logic [SAMPLE_BITS-1:0] sample_two;
		logic [SAMPLE_BITS-1:0] sample_three;
		logic [SAMPLE_BITS-1:0] sample_four;
		logic [SAMPLE_BITS-1:0] sample_five;
		logic [NUM_LOOPS-1:0]   loop_disabled;
		logic                   polarity_pin;
	} lfm_item_t;

	typedef struct packed {
		logic                 alarm_out;
		logic [NUM_LOOPS-1:0] short_leds;
		logic [NUM_LOOPS-1:0] open_leds;
		logic [NUM_REFS-1:0]  reference_leds;
		logic                 buzzer_on;
		logic                 alarm_latched;
	} lfm_result_t;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] open_limit;
		logic [LIMIT_BITS-1:0] short_limit;
		logic [LIMIT_BITS-1:0] alarm_limit;
	} lfm_cfg_t;

	typedef struct packed {
		logic                 alarm_flag;
		logic                 alarm_pin_level;
		logic                 buzzer_running;
		logic                 buzzer_start_next;
		logic [NUM_LOOPS-1:0] short_led_bits;
		logic [NUM_LOOPS-1:0] open_led_bits;
		logic [NUM_REFS-1:0]  reference_led_bits;
		logic [NUM_REFS-1:0]  open_blink_flags;
	} lfm_state_t;

endpackage

>>> src/lfm_eval.sv
module lfm_eval (
	input  lfm_pkg::lfm_item_t  item,
	input  lfm_pkg::lfm_cfg_t   cfg,
	input  lfm_pkg::lfm_state_t state,
	output lfm_pkg::lfm_state_t state_next
);
	import lfm_pkg::*;

	logic [SAMPLE_BITS-1:0] smp [NUM_LOOPS+NUM_REFS];
	logic [NUM_LOOPS+NUM_REFS-1:0] hi;
	logic [NUM_LOOPS+NUM_REFS-1:0] lo;
	logic [NUM_LOOPS-1:0] in_alarm_win;
	logic [NUM_REFS-1:0]  in_ref_win;

	// gather samples into an indexable row
	assign smp[0] = item.sample_zero;
	assign smp[1] = item.sample_one;
	assign smp[2] = item.sample_two;
	assign smp[3] = item.sample_three;
	assign smp[4] = item.sample_four;
	assign smp[5] = item.sample_five;

	// window and limit compares, one set per loop
	always_comb begin
		for (int i = 0; i < NUM_LOOPS + NUM_REFS; i++) begin
			hi[i] = smp[i] > cfg.short_limit;
			lo[i] = smp[i] < cfg.open_limit;
		end
		for (int i = 0; i < NUM_LOOPS; i++) begin
			in_alarm_win[i] = (smp[i] > cfg.open_limit) && (smp[i] < cfg.alarm_limit);
		end
		for (int i = 0; i < NUM_REFS; i++) begin
			in_ref_win[i] = (smp[NUM_LOOPS+i] > cfg.alarm_limit)
				&& (smp[NUM_LOOPS+i] < cfg.short_limit);
		end
	end

	// next state for the current action
	always_comb begin
		state_next = state;
		unique case (item.action)
			ACT_POLARITY: begin
				state_next.alarm_pin_level = state.alarm_flag ^ item.polarity_pin;
			end
			ACT_CHECK: begin
				if (in_ref_win == '0 && in_alarm_win != '0) begin
					state_next.alarm_flag = 1'b1;
				end
			end
			ACT_BLINK: begin
				if (state.alarm_flag) begin
					state_next.buzzer_running    = state.buzzer_start_next;
					state_next.buzzer_start_next = ~state.buzzer_start_next;
					// fault leds of loops 0 to 3
					for (int i = 0; i < NUM_LOOPS; i++) begin
						if (hi[i] || lo[i]) begin
							if (!item.loop_disabled[i]) begin
								state_next.short_led_bits[i] = state.short_led_bits[i] ^ hi[i];
								state_next.open_led_bits[i]  = state.open_led_bits[i] ^ lo[i];
							end else begin
								state_next.short_led_bits[i] = 1'b0;
								state_next.open_led_bits[i]  = 1'b0;
							end
						end
					end
					// reference indicators: an open blinks, a short holds on
					for (int i = 0; i < NUM_REFS; i++) begin
						if (lo[NUM_LOOPS+i]) begin
							state_next.open_blink_flags[i]   = ~state.open_blink_flags[i];
							state_next.reference_led_bits[i] = ~state.open_blink_flags[i];
						end else if (hi[NUM_LOOPS+i]) begin
							state_next.reference_led_bits[i] = 1'b1;
						end
					end
				end
			end
			ACT_BUZZ_TOGGLE: begin
				state_next.buzzer_running    = state.buzzer_start_next;
				state_next.buzzer_start_next = ~state.buzzer_start_next;
			end
			ACT_BUZZ_STOP: begin
				state_next.buzzer_running = 1'b0;
			end
			default: begin
				state_next = state;
			end
		endcase
	end

endmodule

>>> src/loop_fault_monitor.sv
// loop_fault_monitor: alarm and indicator control for four sensor loops and
// two reference loops.
// item channel (item_valid/item_ready/item): one beat is one tick carrying an
// action code and a fresh set of six samples. result channel
// (result_valid/result_ready/result): one beat per item, showing the alarm
// pin, led levels, buzzer and sticky alarm flag after that tick.
// cfg_we/cfg_index/cfg_data write the open, short and alarm limits; write
// them only while no item is in flight.
// an accepted item is registered in the input stage, evaluated from there and
// its result is written to the output register when that is empty or drained.
// throughput: one item per cycle while result_ready is high, set by the single
// compare-and-update pass from the input to the state/output registers.
// the input register keeps taking beats while the output beat waits, as long
// as the output register frees up in the same cycle; when the receiver stalls
// both stages fill and item_ready drops until result_ready returns.
// reset clears all state, the alarm flag included, loads the default limits
// and empties both stages.
module loop_fault_monitor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  lfm_pkg::lfm_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output lfm_pkg::lfm_result_t result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [lfm_pkg::LIMIT_BITS-1:0] cfg_data
);
	import lfm_pkg::*;

	lfm_cfg_t    cfg_q;
	lfm_state_t  state_q;
	lfm_state_t  state_next;
	lfm_item_t   item_s1;
	logic        valid_s1;
	lfm_result_t result_s2;
	logic        valid_s2;
	logic        advance;

	// s1 moves on when the output register is empty or being drained
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_limit  <= OPEN_LIMIT_RST;
			cfg_q.short_limit <= SHORT_LIMIT_RST;
			cfg_q.alarm_limit <= ALARM_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OPEN_LIMIT:  cfg_q.open_limit  <= cfg_data;
				REG_SHORT_LIMIT: cfg_q.short_limit <= cfg_data;
				REG_ALARM_LIMIT: cfg_q.alarm_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	lfm_eval u_eval (
		.item       (item_s1),
		.cfg        (cfg_q),
		.state      (state_q),
		.state_next (state_next)
	);

	// monitor state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.alarm_out      <= state_next.alarm_pin_level;
			result_s2.short_leds     <= state_next.short_led_bits;
			result_s2.open_leds      <= state_next.open_led_bits;
			result_s2.reference_leds <= state_next.reference_led_bits;
			result_s2.buzzer_on      <= state_next.buzzer_running;
			result_s2.alarm_latched  <= state_next.alarm_flag;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// alarm flag is sticky until reset
	a_alarm_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.alarm_flag |=> state_q.alarm_flag)
		else $error("alarm flag cleared without reset");

	// buzzer cannot be running with a pending start
	a_buzzer_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.buzzer_running && state_q.buzzer_start_next))
		else $error("buzzer running with start pending");

	// state only moves when an item passes into the output register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without an item");

	// a waiting result always matches the current state
	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.alarm_latched == state_q.alarm_flag
			&& result_s2.buzzer_on == state_q.buzzer_running
			&& result_s2.short_leds == state_q.short_led_bits
			&& result_s2.open_leds == state_q.open_led_bits))
		else $error("result beat out of step with state");

	// a stalled input stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage dropped an item");

endmodule
